>>> rtl/priority_decay_ready_scheduler_core_assert.svh
// Assertion macros for the priority decay ready scheduler.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef PRIORITY_DECAY_READY_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_DECAY_READY_SCHEDULER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PDRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pdrs_pkg.sv
// Shared types, constants and helpers for the priority decay ready scheduler.
// No dependencies.
`default_nettype none

package pdrs_pkg;

  localparam int NumPrios      = 4;
  localparam int NumFifos      = 2 * NumPrios;
  localparam int FifoW         = $clog2(NumFifos);
  localparam int LevelDepthDef = 64;

  localparam int PidW    = 8;
  localparam int SprioW  = 3;
  localparam int DprioW  = 2;
  localparam int OriginW = 2;
  localparam int PrioW   = 2;

  typedef logic [PrioW-1:0] prio_t;
  typedef logic [FifoW-1:0] fifo_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // origin codes; the unused code behaves as preempted
  localparam logic [OriginW-1:0] ORIG_NEW     = 2'd0;
  localparam logic [OriginW-1:0] ORIG_IO      = 2'd1;
  localparam logic [OriginW-1:0] ORIG_PREEMPT = 2'd2;
  localparam logic [OriginW-1:0] ORIG_SPARE   = 2'd3;

  typedef struct packed {
    cmd_e               cmd;
    logic [PidW-1:0]    proc_id;
    logic [SprioW-1:0]  static_prio;
    logic [DprioW-1:0]  dyn_prio_in;
    logic [OriginW-1:0] origin;
  } in_item_t;

  typedef struct packed {
    logic            valid_res;
    logic [PidW-1:0] proc_out;
    prio_t           prio_out;
    logic            to_expired;
    logic            overflow;
  } out_item_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic exec;  // perform the accepted word's queue operation
    logic load;  // move the finished result into the output register
  } ctrl_cmd_t;

  function automatic prio_t clamp_level(input logic [SprioW-1:0] v);
    clamp_level = (v > SprioW'(NumPrios - 1)) ? prio_t'(NumPrios - 1) : prio_t'(v);
  endfunction

  function automatic fifo_t fifo_idx(input logic bank, input prio_t lvl);
    fifo_idx = bank ? fifo_t'(NumPrios) + fifo_t'(lvl) : fifo_t'(lvl);
  endfunction

endpackage

`default_nettype wire

>>> rtl/pdrs_if.sv
// Valid/ready channel interfaces for the scheduler's input and result words.
// Depends on pdrs_pkg.
`default_nettype none

interface pdrs_in_if;
  import pdrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdrs_out_if;
  import pdrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pdrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pdrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pdrs_ctrl.sv
// Sequencer for the scheduler: accept, then hand the result to the output register.
// Depends on pdrs_pkg and the assertion macro header.
`default_nettype none
`include "priority_decay_ready_scheduler_core_assert.svh"

module pdrs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 out_ready_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output pdrs_pkg::ctrl_cmd_t       cmd_o
);
  import pdrs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.exec = in_valid_i;
      end
      S_RESULT: begin
        cmd_o.load = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PDRS_ASSERT_NEXT(a_exec_to_result, cmd_o.exec, state_q == S_RESULT, "exec did not enter result")
  `PDRS_ASSERT_NEXT(a_load_shows_word, cmd_o.load, out_valid_q, "loaded word not presented")
  `PDRS_ASSERT_NEXT(a_result_waits, (state_q == S_RESULT) && !out_free,
                    state_q == S_RESULT, "result left while output busy")

endmodule

`default_nettype wire

>>> rtl/pdrs_dp.sv
// Datapath: level FIFO pointers and counts, bank select, entry memory, result regs.
// Depends on pdrs_pkg, pdrs_ram and the assertion macro header.
`default_nettype none
`include "priority_decay_ready_scheduler_core_assert.svh"

module pdrs_dp #(
  parameter int LevelDepth = pdrs_pkg::LevelDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pdrs_pkg::ctrl_cmd_t cmd_i,
  input  wire pdrs_pkg::in_item_t  in_data_i,
  output pdrs_pkg::out_item_t      out_data_o
);
  import pdrs_pkg::*;

  localparam int HeadW    = $clog2(LevelDepth);
  localparam int CntW     = $clog2(LevelDepth + 1);
  localparam int SumW     = CntW + 1;
  localparam int AddrW    = FifoW + HeadW;
  localparam int RamDepth = 2 ** AddrW;

  logic [HeadW-1:0] head_q [NumFifos];
  logic [HeadW-1:0] head_d [NumFifos];
  logic [CntW-1:0]  cnt_q  [NumFifos];
  logic [CntW-1:0]  cnt_d  [NumFifos];
  logic             act_q, act_d;

  logic             res_valid_q, res_exp_q, res_ovf_q;
  prio_t            res_prio_q;
  out_item_t        out_data_q;

  // enqueue priority decision
  logic             is_deq;
  prio_t            reset_prio, enq_prio;
  logic             enq_exp;
  fifo_t            enq_f;

  // dequeue selection
  logic [NumPrios-1:0] nz0, nz1, nz_sel;
  logic             act_empty, act_n, found, any_nz;
  prio_t            deq_lvl;
  fifo_t            deq_f;

  // shared access to the selected FIFO
  fifo_t            f;
  logic [HeadW-1:0] head_f, head_inc, slot;
  logic [CntW-1:0]  cnt_f;
  logic [SumW-1:0]  sum;
  logic             full;

  logic             ram_we, ram_re;
  logic [PidW-1:0]  ram_rdata;

  assign is_deq = (in_data_i.cmd == CMD_DEQ);

  assign reset_prio = clamp_level((in_data_i.static_prio == '0) ? '0
                                  : in_data_i.static_prio - 1'b1);

  always_comb begin
    enq_exp  = 1'b0;
    case (in_data_i.origin)
      ORIG_NEW: enq_prio = clamp_level(SprioW'(in_data_i.dyn_prio_in));
      ORIG_IO:  enq_prio = reset_prio;
      default: begin
        // preempted: decay one level, wrap to the expired bank below zero
        if (in_data_i.dyn_prio_in == '0) begin
          enq_prio = reset_prio;
          enq_exp  = 1'b1;
        end else begin
          enq_prio = clamp_level(SprioW'(in_data_i.dyn_prio_in) - 1'b1);
        end
      end
    endcase
  end

  assign enq_f = fifo_idx(act_q ^ enq_exp, enq_prio);

  always_comb begin
    for (int l = 0; l < NumPrios; l++) begin
      nz0[l] = (cnt_q[l] != '0);
      nz1[l] = (cnt_q[NumPrios + l] != '0);
    end
  end

  assign any_nz    = |{nz0, nz1};
  assign act_empty = act_q ? ~|nz1 : ~|nz0;
  assign act_n     = act_q ^ act_empty;
  assign nz_sel    = act_n ? nz1 : nz0;

  // highest non-empty level wins
  always_comb begin
    found   = 1'b0;
    deq_lvl = '0;
    for (int l = 0; l < NumPrios; l++) begin
      if (nz_sel[l]) begin
        found   = 1'b1;
        deq_lvl = prio_t'(l);
      end
    end
  end

  assign deq_f = fifo_idx(act_n, deq_lvl);
  assign f     = is_deq ? deq_f : enq_f;

  assign head_f   = head_q[f];
  assign cnt_f    = cnt_q[f];
  assign full     = (cnt_f == CntW'(LevelDepth));
  assign sum      = SumW'(head_f) + SumW'(cnt_f);
  assign slot     = (sum >= SumW'(LevelDepth)) ? HeadW'(sum - SumW'(LevelDepth)) : HeadW'(sum);
  assign head_inc = (head_f == HeadW'(LevelDepth - 1)) ? '0 : head_f + 1'b1;

  assign ram_we = cmd_i.exec && !is_deq && !full;
  assign ram_re = cmd_i.exec && is_deq && found;

  pdrs_ram #(
    .Width (PidW),
    .Depth (RamDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({f, slot}),
    .wdata_i (in_data_i.proc_id),
    .re_i    (ram_re),
    .raddr_i ({f, head_f}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    act_d  = act_q;
    if (cmd_i.exec) begin
      if (is_deq) begin
        act_d = act_n;
        if (found) begin
          head_d[f] = head_inc;
          cnt_d[f]  = cnt_f - 1'b1;
        end
      end else if (!full) begin
        cnt_d[f] = cnt_f + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumFifos; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      act_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_valid_q <= is_deq && found;
      res_prio_q  <= is_deq ? (found ? deq_lvl : '0) : enq_prio;
      res_exp_q   <= !is_deq && enq_exp;
      res_ovf_q   <= !is_deq && full;
    end
    if (cmd_i.load) begin
      out_data_q.valid_res  <= res_valid_q;
      out_data_q.proc_out   <= res_valid_q ? ram_rdata : '0;
      out_data_q.prio_out   <= res_prio_q;
      out_data_q.to_expired <= res_exp_q;
      out_data_q.overflow   <= res_ovf_q;
    end
  end

  assign out_data_o = out_data_q;

  `PDRS_ASSERT_NEXT(a_enq_count_up, cmd_i.exec && !is_deq && !full,
                    cnt_q[$past(f)] == CntW'($past(cnt_f) + 1'b1), "enqueue count not bumped")
  `PDRS_ASSERT_NEXT(a_deq_finds, cmd_i.exec && is_deq && any_nz,
                    res_valid_q, "dequeue missed a queued entry")
  `PDRS_ASSERT_NEXT(a_bank_swap, cmd_i.exec && is_deq && act_empty,
                    act_q != $past(act_q), "empty active bank not swapped")
  `PDRS_ASSERT_SAME(a_ram_one_op, ram_we, !ram_re, "entry memory read and write together")

endmodule

`default_nettype wire

>>> rtl/priority_decay_ready_scheduler_core.sv
`default_nettype none
// Ready-queue scheduler with priority decay over an active and an expired bank of
// per-level FIFOs (NumPrios levels per bank, LEVEL_DEPTH entries per level). An
// enqueue word files a process id at a level chosen by its origin: new keeps its
// dynamic priority, back-from-I/O restarts at static minus one, preempted drops one
// level and, when it falls below zero, restarts at static minus one in the expired
// bank. A dequeue word swaps the banks if the active one is empty and pops the oldest
// id of the highest non-empty active level; valid_res is low when nothing is queued.
// A full target level drops the id and sets overflow. Every word gives exactly one
// result word. In the accept cycle the level counts and pointers are updated and the
// entry memory is written or read; in the result state, once the output register is
// free, the registered read data is moved into the output register; the input is
// taken again once that result is loaded, so a stalled result holds off the input.
// The entry memory needs no clearing: only written slots are ever read.
// Depends on pdrs_pkg, pdrs_if, pdrs_ctrl, pdrs_dp and pdrs_ram.

module priority_decay_ready_scheduler_core #(
  parameter int LEVEL_DEPTH = pdrs_pkg::LevelDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pdrs_in_if.sink   in_i,
  pdrs_out_if.source out_o
);
  import pdrs_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // sequencer: one word in flight, result parked until the sink takes it
  pdrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (ctrl_cmd)
  );

  // queue state, entry memory and result registers
  pdrs_dp #(
    .LevelDepth (LEVEL_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .in_data_i  (in_i.data),
    .out_data_o (out_data)
  );

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

`default_nettype wire

>>> sim/priority_decay_ready_scheduler_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_decay_ready_scheduler_core: random and directed
// enqueue/dequeue words against an in-bench copy of the two-bank level FIFOs.
// Depends on pdrs_pkg, pdrs_if and the scheduler RTL.

module priority_decay_ready_scheduler_core_test;
  import pdrs_pkg::*;

  localparam int LEVEL_DEPTH = LevelDepthDef;
  localparam int MAX_SHOWN   = 10;
  localparam int REPLY_SLOTS = 16;

  logic clk_i;
  logic rst_ni;

  pdrs_in_if  in_ch ();
  pdrs_out_if out_ch ();

  priority_decay_ready_scheduler_core #(
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // bench copy of the scheduler state
  logic [PidW-1:0] lvl_mem   [NumFifos][LEVEL_DEPTH];
  int              lvl_head  [NumFifos];
  int              lvl_count [NumFifos];
  logic            live_bank;

  // expected replies, oldest first
  out_item_t reply_fifo [REPLY_SLOTS];
  int        reply_wr   = 0;
  int        reply_rd   = 0;
  int        mismatches = 0;
  bit        no_idle    = 1'b0;

  function automatic int reply_pending();
    return reply_wr - reply_rd;
  endfunction

  function automatic void reply_stash(input out_item_t r);
    reply_fifo[reply_wr % REPLY_SLOTS] = r;
    reply_wr++;
  endfunction

  function automatic out_item_t reply_take();
    out_item_t r;
    r = reply_fifo[reply_rd % REPLY_SLOTS];
    reply_rd++;
    return r;
  endfunction

  // Applies one word to the bench state and returns the reply it must produce.
  function automatic out_item_t run_queue_step(input in_item_t w);
    out_item_t r;
    prio_t     restart_lvl;
    logic      bank;
    logic      busy;
    int        tmp;
    int        f;
    int        slot;
    r = '0;
    tmp = (w.static_prio == 0) ? 0 : int'(w.static_prio) - 1;
    restart_lvl = (tmp > NumPrios - 1) ? prio_t'(NumPrios - 1) : prio_t'(tmp);
    if (w.cmd == CMD_ENQ) begin
      bank = live_bank;
      if (w.origin == ORIG_NEW) begin
        r.prio_out = (int'(w.dyn_prio_in) > NumPrios - 1) ? prio_t'(NumPrios - 1)
                                                          : prio_t'(w.dyn_prio_in);
      end else if (w.origin == ORIG_IO) begin
        r.prio_out = restart_lvl;
      end else if (w.dyn_prio_in == 0) begin
        // decay wrapped below zero: restart level, parked in the expired bank
        r.prio_out   = restart_lvl;
        bank         = ~bank;
        r.to_expired = 1'b1;
      end else begin
        r.prio_out = prio_t'(w.dyn_prio_in - 1);
      end
      f = int'(bank) * NumPrios + int'(r.prio_out);
      if (lvl_count[f] >= LEVEL_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        slot = (lvl_head[f] + lvl_count[f]) % LEVEL_DEPTH;
        lvl_mem[f][slot] = w.proc_id;
        lvl_count[f]++;
      end
    end else begin
      busy = 1'b0;
      for (int l = 0; l < NumPrios; l++)
        if (lvl_count[int'(live_bank) * NumPrios + l] != 0) busy = 1'b1;
      if (!busy) live_bank = ~live_bank;
      for (int l = NumPrios - 1; l >= 0; l--) begin
        f = int'(live_bank) * NumPrios + l;
        if (!r.valid_res && lvl_count[f] != 0) begin
          r.valid_res = 1'b1;
          r.proc_out  = lvl_mem[f][lvl_head[f]];
          r.prio_out  = prio_t'(l);
          lvl_head[f] = (lvl_head[f] + 1) % LEVEL_DEPTH;
          lvl_count[f]--;
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t enq_word(input int pid, input int sprio, input int dyn,
                                        input logic [OriginW-1:0] orig);
    in_item_t w;
    w.cmd         = CMD_ENQ;
    w.proc_id     = PidW'(pid);
    w.static_prio = SprioW'(sprio);
    w.dyn_prio_in = DprioW'(dyn);
    w.origin      = orig;
    return w;
  endfunction

  function automatic in_item_t deq_word();
    in_item_t w;
    w = in_item_t'($bits(in_item_t)'($urandom));
    w.cmd = CMD_DEQ;
    return w;
  endfunction

  // Random word; static priority is mostly in its nominal range, sometimes anywhere.
  function automatic in_item_t random_word(input int deq_pct);
    int sprio;
    if ($urandom_range(0, 99) < deq_pct) return deq_word();
    sprio = ($urandom_range(0, 9) < 8) ? $urandom_range(1, NumPrios) : $urandom_range(0, 7);
    return enq_word($urandom_range(0, 255), sprio, $urandom_range(0, 3),
                    OriginW'($urandom_range(0, 3)));
  endfunction

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  // Offers one word after a random gap and records its reply once accepted.
  task automatic send_word(input in_item_t w);
    int gap;
    gap = idle_draw();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    reply_stash(run_queue_step(w));
  endtask

  task automatic park_sender();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  // Result side: random stall, then take and check one reply word.
  initial begin : reply_checker
    int        stall;
    out_item_t got;
    out_item_t want;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = idle_draw();
      repeat (stall) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = out_ch.data;
      if (reply_pending() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: reply with nothing pending: valid=%0b pid=%0h prio=%0d exp=%0b ovf=%0b",
                   $realtime, got.valid_res, got.proc_out, got.prio_out, got.to_expired,
                   got.overflow);
      end else begin
        want = reply_take();
        if (got.valid_res !== want.valid_res || got.proc_out !== want.proc_out ||
            got.prio_out !== want.prio_out || got.to_expired !== want.to_expired ||
            got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display({"%0t: mismatch want valid=%0b pid=%0h prio=%0d exp=%0b ovf=%0b,",
                      " got valid=%0b pid=%0h prio=%0d exp=%0b ovf=%0b"},
                     $realtime, want.valid_res, want.proc_out, want.prio_out,
                     want.to_expired, want.overflow, got.valid_res, got.proc_out,
                     got.prio_out, got.to_expired, got.overflow);
        end
      end
    end
  end

  // Each origin, priority saturation at both ends, decay wrap, bank swap, empty dequeue.
  task automatic test_directed_priorities();
    send_word(deq_word());                       // both banks empty
    send_word(enq_word(8'h00, 1, 0, ORIG_NEW));
    send_word(enq_word(8'hFF, 4, 3, ORIG_NEW));
    send_word(enq_word(8'h5A, 4, 0, ORIG_IO));
    send_word(enq_word(8'hA5, 0, 3, ORIG_IO));   // static zero saturates low
    send_word(enq_word(8'h3C, 7, 1, ORIG_IO));   // static above range saturates high
    send_word(enq_word(8'hC3, 2, 3, ORIG_PREEMPT));
    send_word(enq_word(8'h81, 3, 0, ORIG_PREEMPT));   // wraps into expired bank
    send_word(enq_word(8'h7E, 1, 2, ORIG_SPARE));     // unused origin acts as preempted
    send_word(enq_word(8'h01, 0, 0, ORIG_SPARE));     // wrap with static zero
    send_word(enq_word(8'h80, 4, 1, ORIG_PREEMPT));
    repeat (11) send_word(deq_word());           // drain active, swap, drain expired
  endtask

  task automatic test_mixed_traffic(input int n);
    for (int i = 0; i < n; i++) send_word(random_word(45));
  endtask

  // Enqueue-heavy and aimed at one level so that level FIFOs fill and drop ids.
  task automatic test_level_overflow(input int n);
    in_item_t w;
    for (int i = 0; i < n; i++) begin
      w = random_word(5);
      if (w.cmd == CMD_ENQ && $urandom_range(0, 9) < 6) begin
        w.origin      = ORIG_NEW;
        w.dyn_prio_in = 2'd3;
      end
      send_word(w);
    end
    // hold off until every pending reply is back
    park_sender();
    while (reply_pending() != 0) @(posedge clk_i);
  endtask

  // Dequeue-heavy: empties banks repeatedly so swaps and empty replies occur.
  task automatic test_drain_and_swap(input int n);
    for (int i = 0; i < n; i++) send_word(random_word(85));
  endtask

  task automatic test_back_to_back(input int n);
    no_idle = 1'b1;
    for (int i = 0; i < n; i++) send_word(random_word(50));
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    live_bank    = 1'b0;
    for (int f = 0; f < NumFifos; f++) begin
      lvl_head[f]  = 0;
      lvl_count[f] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_priorities();
    test_mixed_traffic(450);
    test_level_overflow(300);
    test_drain_and_swap(250);
    test_back_to_back(150);

    park_sender();
    while (reply_pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pdrs_pkg.sv
rtl/pdrs_if.sv
rtl/pdrs_ram.sv
rtl/pdrs_ctrl.sv
rtl/pdrs_dp.sv
rtl/priority_decay_ready_scheduler_core.sv
sim/priority_decay_ready_scheduler_core_test.sv
